[rtl/pttt_pkg.sv]
// Package for the pending task timeout table.
// Holds request codes, result kinds and the controller/datapath command and status structs.
// No dependencies.
package pttt_pkg;

    typedef enum logic [2:0] {
        REQ_SAVE  = 3'd0,
        REQ_STOP  = 3'd1,
        REQ_QUERY = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_REDO  = 3'd4,
        REQ_CHECK = 3'd5,
        REQ_CORE  = 3'd6
    } req_code_t;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;

    localparam logic [31:0] RETRY_DEFAULT = 32'd60000;

    typedef struct packed {
        logic in_rdy;
        logic calc_idle;
        logic core_start;
        logic save_do;
        logic clear_all;
        logic rank_clr;
        logic rank_inc;
        logic rd;
        logic age;
        logic remove;
        logic mark_done;
        logic emit;
        logic emit_done;
        logic set_ok;
        logic clr_ok;
        logic min_clr;
        logic min_upd;
        logic cur_load;
        logic cur_clr;
    } cmd_t;

    typedef struct packed {
        logic       in_take;
        logic [2:0] op;
        logic       out_free;
        logic       rank_end;
        logic       id_match;
        logic       slot_sel;
        logic       expire;
        logic       retry_ok;
        logic       min_found;
    } sts_t;

endpackage

[rtl/pttt_if.sv]
// Channel interfaces of the pending task timeout table: request, result, configuration.
// Valid/ready handshake; no package dependency.
interface pttt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] task_id;
    logic [7:0]  priority_req;
    logic signed [31:0] timeout_ms;
    logic [31:0] cost_ms;
    logic        net_sensitive;
    logic [63:0] now_ms;

    modport source (output valid, req_type, task_id, priority_req, timeout_ms, cost_ms,
                    net_sensitive, now_ms, input ready);
    modport sink (input valid, req_type, task_id, priority_req, timeout_ms, cost_ms,
                  net_sensitive, now_ms, output ready);
endinterface

interface pttt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] out_task_id;
    logic [7:0]  out_priority;
    logic [30:0] remaining_ms;
    logic [31:0] elapsed_ms;
    logic        ok;
    logic        last;

    modport source (output valid, kind, out_task_id, out_priority, remaining_ms,
                    elapsed_ms, ok, last, input ready);
    modport sink (input valid, kind, out_task_id, out_priority, remaining_ms,
                  elapsed_ms, ok, last, output ready);
endinterface

interface pttt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] hold_ms;

    modport source (output valid, hold_ms, input ready);
    modport sink (input valid, hold_ms, output ready);
endinterface

[rtl/pending_task_timeout_table.sv]
// Pending task timeout table: parks tasks and restarts or fails them on redo and check.
// Channels: req (request in), rsp (result out), cfg (retry interval write, always ready).
// Every request gives zero or more restart/fail results and then one done result with last set.
// req.ready is high only while the block is idle; one request is in work at a time.
// Save: decode, then the table write, then the done result.
// Clear, core-started and unknown requests: decode, then the done result.
// Stop and query walk entries in save order, with a read, age and evaluate step per entry visited.
// Check walks all n entries in save order, with a read, age and evaluate step for each.
// Redo runs one pass per distinct priority plus one.
// The walk speed is set by the payload RAM read and the registered age subtraction.
// The result register lets the next request be accepted while the done result waits.
// A stalled receiver holds the walk at the next result; nothing is dropped.
// Reset empties the table, sets the core start time to zero and retry interval to 60000 ms.
// Depends on pttt_pkg, pttt_if, pttt_ctrl, pttt_dp, pttt_ram.
module pending_task_timeout_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    pttt_req_if.sink    req,
    pttt_rsp_if.source  rsp,
    pttt_cfg_if.sink    cfg
);
    pttt_pkg::cmd_t cmd;
    pttt_pkg::sts_t sts;

    pttt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pttt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.emit_done) |-> sts.out_free)
        else $error("result loaded over waiting result");

    a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.emit_done))
        else $error("two results loaded at once");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |=> req.ready)
        else $error("not idle after done result");
endmodule

[rtl/pttt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/pttt_ctrl.sv]
// Controller state machine of the pending task timeout table.
// Depends on pttt_pkg; drives commands to pttt_dp and reads its status.
module pttt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  pttt_pkg::sts_t sts,
    output pttt_pkg::cmd_t cmd
);
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_SAVE   = 7'b0000100,
        ST_RD     = 7'b0001000,
        ST_WAIT   = 7'b0010000,
        ST_EVAL   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_rdy = 1'b1;
                if (sts.in_take)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.calc_idle = 1'b1;
                cmd.rank_clr  = 1'b1;
                cmd.clr_ok    = 1'b1;
                cmd.min_clr   = 1'b1;
                cmd.cur_clr   = 1'b1;
                case (sts.op)
                    pttt_pkg::REQ_SAVE:
                    begin
                        state_next = ST_SAVE;
                    end
                    pttt_pkg::REQ_STOP, pttt_pkg::REQ_QUERY,
                    pttt_pkg::REQ_REDO, pttt_pkg::REQ_CHECK:
                    begin
                        state_next = ST_RD;
                    end
                    pttt_pkg::REQ_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_DONE;
                    end
                    pttt_pkg::REQ_CORE:
                    begin
                        cmd.core_start = 1'b1;
                        state_next     = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SAVE:
            begin
                cmd.save_do = 1'b1;
                state_next  = ST_DONE;
            end
            ST_RD:
            begin
                if (sts.rank_end)
                begin
                    if (sts.op == pttt_pkg::REQ_REDO)
                    begin
                        if (sts.min_found)
                        begin
                            cmd.cur_load = 1'b1;
                            cmd.min_clr  = 1'b1;
                            cmd.rank_clr = 1'b1;
                        end
                        else
                        begin
                            cmd.clear_all = 1'b1;
                            state_next    = ST_DONE;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                cmd.age    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                case (sts.op)
                    pttt_pkg::REQ_STOP, pttt_pkg::REQ_QUERY:
                    begin
                        if (sts.id_match)
                        begin
                            cmd.set_ok = 1'b1;
                            cmd.remove = (sts.op == pttt_pkg::REQ_STOP);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.rank_inc = 1'b1;
                            state_next   = ST_RD;
                        end
                    end
                    pttt_pkg::REQ_CHECK:
                    begin
                        if (sts.expire || sts.retry_ok)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.remove = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                        else
                        begin
                            cmd.rank_inc = 1'b1;
                            state_next   = ST_RD;
                        end
                    end
                    pttt_pkg::REQ_REDO:
                    begin
                        if (sts.slot_sel)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.mark_done = 1'b1;
                                cmd.rank_inc  = 1'b1;
                                state_next    = ST_RD;
                            end
                        end
                        else
                        begin
                            cmd.min_upd  = 1'b1;
                            cmd.rank_inc = 1'b1;
                            state_next   = ST_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/pttt_dp.sv]
// Datapath of the pending task timeout table: entry flags, ranks, priorities,
// payload RAM, age arithmetic and the result register. Depends on pttt_pkg, pttt_if, pttt_ram.
module pttt_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    pttt_req_if.sink        req,
    pttt_rsp_if.source      rsp,
    pttt_cfg_if.sink        cfg,
    input  pttt_pkg::cmd_t  cmd,
    output pttt_pkg::sts_t  sts
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = 32 + 31 + 64;

    logic [2:0]  op_reg;
    logic [31:0] id_reg;
    logic [7:0]  prio_in_reg;
    logic [31:0] tmo_reg;
    logic [31:0] cost_reg;
    logic        net_reg;
    logic [63:0] now_reg;
    logic [63:0] lcs_reg;
    logic [31:0] retry_reg;
    logic        idle_ok_reg;

    logic          valid_reg [TABLE_DEPTH];
    logic          done_reg  [TABLE_DEPTH];
    logic [IW-1:0] order_reg [TABLE_DEPTH];
    logic [7:0]    prio_reg  [TABLE_DEPTH];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rank_reg;
    logic [IW-1:0] slot_reg;
    logic [63:0]   age_reg;
    logic          ok_reg;
    logic [7:0]    min_reg;
    logic          min_found_reg;
    logic [7:0]    cur_reg;
    logic          cur_vld_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_id_reg;
    logic [7:0]  out_prio_reg;
    logic [30:0] out_rem_reg;
    logic [31:0] out_el_reg;
    logic        out_ok_reg;
    logic        out_last_reg;

    logic [IW-1:0] rank_slot;
    logic [IW-1:0] free_slot;
    logic [33:0]   rem_calc;
    logic          save_ok;
    logic          take;
    logic [RW-1:0] ram_rdata;
    logic [31:0]   rd_id;
    logic [30:0]   rd_rem;
    logic [63:0]   rd_saved;
    logic [IW-1:0] rm_ord;
    logic [7:0]    sel_prio;
    logic          sel_done;
    logic          out_free;
    logic          expire;

    assign take      = req.valid && req.ready;
    assign req.ready = cmd.in_rdy;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        rank_slot = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (valid_reg[i] && (CW'(order_reg[i]) == rank_reg))
            begin
                rank_slot = IW'(i);
            end
        end
    end

    always_comb
    begin
        free_slot = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    assign rem_calc = {{2{tmo_reg[31]}}, tmo_reg} - {2'b00, cost_reg};
    assign save_ok  = !net_reg && !rem_calc[33] && (rem_calc != '0)
                      && (cnt_reg != CW'(TABLE_DEPTH));

    pttt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.save_do && save_ok),
        .waddr (free_slot),
        .wdata ({id_reg, rem_calc[30:0], now_reg}),
        .re    (cmd.rd),
        .raddr (rank_slot),
        .rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[RW-1 -: 32];
    assign rd_rem   = ram_rdata[94:64];
    assign rd_saved = ram_rdata[63:0];
    assign rm_ord   = order_reg[slot_reg];
    assign sel_prio = prio_reg[slot_reg];
    assign sel_done = done_reg[slot_reg];
    assign out_free = !out_valid_reg || rsp.ready;
    assign expire   = age_reg >= {33'd0, rd_rem};

    assign sts.in_take   = take;
    assign sts.op        = op_reg;
    assign sts.out_free  = out_free;
    assign sts.rank_end  = rank_reg == cnt_reg;
    assign sts.id_match  = rd_id == id_reg;
    assign sts.slot_sel  = cur_vld_reg && !sel_done && (sel_prio == cur_reg);
    assign sts.expire    = expire;
    assign sts.retry_ok  = idle_ok_reg && (age_reg >= {32'd0, retry_reg});
    assign sts.min_found = min_found_reg;

    // request fields and payload without reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg      <= req.req_type;
            id_reg      <= req.task_id;
            prio_in_reg <= req.priority_req;
            tmo_reg     <= req.timeout_ms;
            cost_reg    <= req.cost_ms;
            net_reg     <= req.net_sensitive;
            now_reg     <= req.now_ms;
        end
        if (cmd.rd)
        begin
            slot_reg <= rank_slot;
        end
        if (cmd.age)
        begin
            age_reg <= now_reg - rd_saved;
        end
        if (cmd.calc_idle)
        begin
            idle_ok_reg <= (now_reg - lcs_reg) >= {32'd0, retry_reg};
        end
        if (cmd.cur_load)
        begin
            cur_reg <= min_reg;
        end
        if (cmd.min_upd && !sel_done && (!min_found_reg || (sel_prio < min_reg)))
        begin
            min_reg <= sel_prio;
        end
        for (int t = 0; t < TABLE_DEPTH; t++)
        begin
            if (cmd.save_do && save_ok && (IW'(t) == free_slot))
            begin
                order_reg[t] <= IW'(cnt_reg);
                prio_reg[t]  <= prio_in_reg;
            end
            else if (cmd.remove && valid_reg[t] && (order_reg[t] > rm_ord))
            begin
                order_reg[t] <= order_reg[t] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcs_reg       <= '0;
            retry_reg     <= pttt_pkg::RETRY_DEFAULT;
            cnt_reg       <= '0;
            rank_reg      <= '0;
            ok_reg        <= 1'b0;
            min_found_reg <= 1'b0;
            cur_vld_reg   <= 1'b0;
            for (int t = 0; t < TABLE_DEPTH; t++)
            begin
                valid_reg[t] <= 1'b0;
                done_reg[t]  <= 1'b0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                retry_reg <= cfg.hold_ms;
            end
            if (cmd.core_start)
            begin
                lcs_reg <= now_reg;
            end
            if (cmd.rank_clr)
            begin
                rank_reg <= '0;
            end
            else if (cmd.rank_inc)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
            if (cmd.clr_ok)
            begin
                ok_reg <= 1'b0;
            end
            else if (cmd.set_ok || (cmd.save_do && save_ok))
            begin
                ok_reg <= 1'b1;
            end
            if (cmd.min_clr)
            begin
                min_found_reg <= 1'b0;
            end
            else if (cmd.min_upd && !sel_done)
            begin
                min_found_reg <= 1'b1;
            end
            if (cmd.cur_clr)
            begin
                cur_vld_reg <= 1'b0;
            end
            else if (cmd.cur_load)
            begin
                cur_vld_reg <= 1'b1;
            end
            if (cmd.clear_all)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.save_do && save_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.remove)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            for (int t = 0; t < TABLE_DEPTH; t++)
            begin
                if (cmd.clear_all)
                begin
                    valid_reg[t] <= 1'b0;
                    done_reg[t]  <= 1'b0;
                end
                else
                begin
                    if (cmd.save_do && save_ok && (IW'(t) == free_slot))
                    begin
                        valid_reg[t] <= 1'b1;
                    end
                    else if (cmd.remove && (IW'(t) == slot_reg))
                    begin
                        valid_reg[t] <= 1'b0;
                    end
                    if (cmd.mark_done && (IW'(t) == slot_reg))
                    begin
                        done_reg[t] <= 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= expire ? pttt_pkg::KIND_FAIL : pttt_pkg::KIND_RESTART;
            out_id_reg   <= rd_id;
            out_prio_reg <= sel_prio;
            out_rem_reg  <= expire ? 31'd0 : (rd_rem - age_reg[30:0]);
            out_el_reg   <= expire ? age_reg[31:0] : 32'd0;
            out_ok_reg   <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_done)
        begin
            out_kind_reg <= pttt_pkg::KIND_ACK;
            out_id_reg   <= '0;
            out_prio_reg <= '0;
            out_rem_reg  <= '0;
            out_el_reg   <= '0;
            out_ok_reg   <= ok_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = out_kind_reg;
    assign rsp.out_task_id  = out_id_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.remaining_ms = out_rem_reg;
    assign rsp.elapsed_ms   = out_el_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.last         = out_last_reg;
endmodule

[verif/tb_pending_task_timeout_table.sv]
`timescale 1ns / 100ps
// Testbench for pending_task_timeout_table: a scoreboard predicts every result of each request.
// Directed and random requests are sent under several retry intervals, with random gaps and stalls.
// Depends on pttt_pkg, pttt_if and the pending_task_timeout_table RTL.
module tb_pending_task_timeout_table;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct {
        logic [2:0]         op;
        logic [31:0]        id;
        logic [7:0]         prio;
        logic signed [31:0] tmo;
        logic [31:0]        cost;
        logic               net;
        logic [63:0]        now;
    } task_req_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [7:0]  prio;
        logic [30:0] rem;
        logic [31:0] el;
        logic        ok;
        logic        last;
    } task_rsp_t;

    logic clk;
    logic rst_n;

    pttt_req_if req ();
    pttt_rsp_if rsp ();
    pttt_cfg_if cfg ();

    pending_task_timeout_table #(.TABLE_DEPTH(DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    task_req_t pend_reqs[$];
    task_rsp_t want_rsps[$];
    task_req_t cur_req;
    int sent_cnt;
    int acc_cnt;
    int req_gap;
    int rsp_stall;
    bit quiet;
    int errors;
    int rsp_cnt;
    int cycles;
    int restarts;
    int fails;
    int fulls;

    bit          tv[DEPTH];
    logic [31:0] tid[DEPTH];
    logic [7:0]  tpr[DEPTH];
    logic [30:0] trem[DEPTH];
    logic [63:0] tsav[DEPTH];
    int          tord[DEPTH];
    logic [63:0] core_at;
    logic [31:0] retry_ms;
    logic [63:0] clock_ms;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int pick_gap();
        int p;
        p = int'($urandom_range(0, 99));
        if (quiet || p < 45) return 0;
        if (p < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int s = 0; s < DEPTH; s++)
            if (tv[s]) n++;
        return n;
    endfunction

    function automatic void by_save_order(ref int lst[$]);
        lst.delete();
        for (int r = 0; r < DEPTH; r++)
            for (int s = 0; s < DEPTH; s++)
                if (tv[s] && tord[s] == r)
                begin
                    lst.insert(lst.size(), s);
                    break;
                end
    endfunction

    function automatic void drop_slot(int s);
        tv[s] = 1'b0;
        for (int t = 0; t < DEPTH; t++)
            if (tv[t] && tord[t] > tord[s]) tord[t]--;
    endfunction

    function automatic int find_task(logic [31:0] id);
        int lst[$];
        by_save_order(lst);
        foreach (lst[i])
            if (tid[lst[i]] == id) return lst[i];
        return -1;
    endfunction

    function automatic void push_rsp(logic [1:0] kind, int s, logic [30:0] rem,
                                     logic [31:0] el, logic ok, logic last);
        task_rsp_t e;
        e.kind = kind;
        e.id = (s >= 0) ? tid[s] : 32'd0;
        e.prio = (s >= 0) ? tpr[s] : 8'd0;
        e.rem = rem;
        e.el = el;
        e.ok = ok;
        e.last = last;
        want_rsps.insert(want_rsps.size(), e);
        if (kind == pttt_pkg::KIND_RESTART) restarts++;
        if (kind == pttt_pkg::KIND_FAIL) fails++;
    endfunction

    function automatic void emit_entry(int s, logic [63:0] now);
        logic [63:0] age;
        age = now - tsav[s];
        if (age >= {33'd0, trem[s]})
            push_rsp(pttt_pkg::KIND_FAIL, s, 31'd0, age[31:0], 1'b0, 1'b0);
        else
            push_rsp(pttt_pkg::KIND_RESTART, s, trem[s] - age[30:0], 32'd0, 1'b0, 1'b0);
    endfunction

    function automatic void table_apply(task_req_t r);
        int lst[$];
        int s;
        int j;
        int placed;
        longint rem;
        logic [63:0] age;
        logic [63:0] idle;
        logic ok;
        ok = 1'b0;
        case (r.op)
            pttt_pkg::REQ_SAVE:
            begin
                rem = longint'(r.tmo) - longint'({32'd0, r.cost});
                if (!r.net && rem > 0)
                begin
                    placed = 0;
                    for (s = 0; s < DEPTH; s++)
                        if (!tv[s])
                        begin
                            tord[s] = live_count();
                            tv[s] = 1'b1;
                            tid[s] = r.id;
                            tpr[s] = r.prio;
                            trem[s] = rem[30:0];
                            tsav[s] = r.now;
                            ok = 1'b1;
                            placed = 1;
                            break;
                        end
                    if (!placed) fulls++;
                end
            end
            pttt_pkg::REQ_STOP:
            begin
                s = find_task(r.id);
                if (s >= 0)
                begin
                    drop_slot(s);
                    ok = 1'b1;
                end
            end
            pttt_pkg::REQ_QUERY: ok = (find_task(r.id) >= 0);
            pttt_pkg::REQ_CLEAR:
                for (s = 0; s < DEPTH; s++) tv[s] = 1'b0;
            pttt_pkg::REQ_REDO:
            begin
                by_save_order(lst);
                for (int i = 1; i < lst.size(); i++)
                begin
                    s = lst[i];
                    j = i;
                    while (j > 0 && tpr[lst[j - 1]] > tpr[s])
                    begin
                        lst[j] = lst[j - 1];
                        j--;
                    end
                    lst[j] = s;
                end
                foreach (lst[i]) emit_entry(lst[i], r.now);
                for (s = 0; s < DEPTH; s++) tv[s] = 1'b0;
            end
            pttt_pkg::REQ_CHECK:
            begin
                idle = r.now - core_at;
                by_save_order(lst);
                foreach (lst[i])
                begin
                    s = lst[i];
                    age = r.now - tsav[s];
                    if (age >= {33'd0, trem[s]} ||
                        (age >= {32'd0, retry_ms} && idle >= {32'd0, retry_ms}))
                    begin
                        emit_entry(s, r.now);
                        drop_slot(s);
                    end
                end
            end
            pttt_pkg::REQ_CORE: core_at = r.now;
            default: ;
        endcase
        push_rsp(pttt_pkg::KIND_ACK, -1, 31'd0, 32'd0, ok, 1'b1);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req.valid || acc_cnt == sent_cnt))
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req.valid <= 1'b0;
            end
            else if (pend_reqs.size() > 0)
            begin
                cur_req = pend_reqs.pop_front();
                req.req_type <= cur_req.op;
                req.task_id <= cur_req.id;
                req.priority_req <= cur_req.prio;
                req.timeout_ms <= cur_req.tmo;
                req.cost_ms <= cur_req.cost;
                req.net_sensitive <= cur_req.net;
                req.now_ms <= cur_req.now;
                req.valid <= 1'b1;
                sent_cnt++;
                req_gap = pick_gap();
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            table_apply(cur_req);
            acc_cnt++;
        end
    end

    // result sink with stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                rsp_stall = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        task_rsp_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_cnt++;
            if (want_rsps.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d id %h", $time, rsp.kind,
                         rsp.out_task_id);
                errors++;
            end
            else
            begin
                e = want_rsps.pop_front();
                if (rsp.kind !== e.kind || rsp.out_task_id !== e.id ||
                    rsp.out_priority !== e.prio || rsp.remaining_ms !== e.rem ||
                    rsp.elapsed_ms !== e.el || rsp.ok !== e.ok || rsp.last !== e.last)
                begin
                    $display("%0t: expected kind %0d id %h prio %0d rem %0d el %0d ok %b last %b",
                             $time, e.kind, e.id, e.prio, e.rem, e.el, e.ok, e.last);
                    $display("%0t: actual   kind %0d id %h prio %0d rem %0d el %0d ok %b last %b",
                             $time, rsp.kind, rsp.out_task_id, rsp.out_priority,
                             rsp.remaining_ms, rsp.elapsed_ms, rsp.ok, rsp.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     want_rsps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic task_req_t mk_req(logic [2:0] op, logic [31:0] id, logic [7:0] prio,
                                         logic [31:0] tmo, logic [31:0] cost, logic net);
        task_req_t r;
        r.op = op;
        r.id = id;
        r.prio = prio;
        r.tmo = tmo;
        r.cost = cost;
        r.net = net;
        r.now = clock_ms;
        return r;
    endfunction

    task automatic add(task_req_t r);
        pend_reqs.insert(pend_reqs.size(), r);
    endtask

    task automatic advance(int lo, int hi);
        if ($urandom_range(0, 39) == 0)
            clock_ms = {$urandom, $urandom};
        else
            clock_ms = clock_ms + {32'd0, $urandom_range(lo, hi)};
    endtask

    task automatic add_random();
        int p;
        logic [31:0] id;
        logic [7:0] prio;
        logic [31:0] tmo;
        logic [31:0] cost;
        p = int'($urandom_range(0, 99));
        id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15);
        prio = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
        tmo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 200000);
        cost = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
        advance(0, 40000);
        if (p < 45)
            add(mk_req(pttt_pkg::REQ_SAVE, id, prio, tmo, cost, $urandom_range(0, 9) == 0));
        else if (p < 55)
            add(mk_req(pttt_pkg::REQ_STOP, id, prio, tmo, cost, 1'b0));
        else if (p < 65)
            add(mk_req(pttt_pkg::REQ_QUERY, id, prio, tmo, cost, 1'b0));
        else if (p < 68)
            add(mk_req(pttt_pkg::REQ_CLEAR, id, prio, tmo, cost, 1'b0));
        else if (p < 75)
            add(mk_req(pttt_pkg::REQ_REDO, id, prio, tmo, cost, 1'b0));
        else if (p < 90)
            add(mk_req(pttt_pkg::REQ_CHECK, id, prio, tmo, cost, 1'b0));
        else
            add(mk_req(pttt_pkg::REQ_CORE, id, prio, tmo, cost, 1'b0));
    endtask

    task automatic drain();
        while (pend_reqs.size() > 0 || req.valid || want_rsps.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_retry(logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.hold_ms <= val;
        do @(posedge clk); while (!cfg.ready);
        retry_ms = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] retry_set[4];
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = pttt_pkg::REQ_SAVE;
        req.task_id = '0;
        req.priority_req = '0;
        req.timeout_ms = '0;
        req.cost_ms = '0;
        req.net_sensitive = 1'b0;
        req.now_ms = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.hold_ms = '0;
        for (int s = 0; s < DEPTH; s++) tv[s] = 1'b0;
        core_at = '0;
        retry_ms = pttt_pkg::RETRY_DEFAULT;
        clock_ms = 64'd1000;
        retry_set[0] = 32'd0;
        retry_set[1] = 32'hFFFF_FFFF;
        retry_set[2] = 32'd5000;
        retry_set[3] = $urandom_range(1, 100000);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add(mk_req(pttt_pkg::REQ_SAVE, 32'hFFFF_FFFF, 8'd255, 32'h7FFF_FFFF, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd0, 8'd0, 32'h8000_0000, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd1, 8'd3, 32'd5, 32'd5, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd1, 8'd3, 32'd6, 32'd5, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd2, 8'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd2, 8'd1, 32'd90000, 32'd100, 1'b1));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd1, 8'd0, 32'd200000, 32'd1, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd3, 8'd3, 32'd70000, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_QUERY, 32'd1, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_QUERY, 32'd9, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_STOP, 32'd1, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_STOP, 32'd9, 8'd0, 32'd0, 32'd0, 1'b0));
        clock_ms = clock_ms + 64'd65000;
        add(mk_req(pttt_pkg::REQ_CHECK, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_CORE, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
        clock_ms = clock_ms + 64'd61000;
        add(mk_req(pttt_pkg::REQ_CHECK, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd4, 8'd2, 32'd50, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd5, 8'd2, 32'd500000, 32'd0, 1'b0));
        clock_ms = clock_ms + 64'd100;
        add(mk_req(pttt_pkg::REQ_REDO, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_REDO, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_SAVE, 32'd6, 8'd1, 32'd100, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_CLEAR, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
        add(mk_req(pttt_pkg::REQ_QUERY, 32'd6, 8'd0, 32'd0, 32'd0, 1'b0));
        repeat (60) add_random();
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_retry(retry_set[ph]);
            quiet = (ph == 2);
            if (ph == 1)
            begin
                // fill past capacity, then flush by priority
                for (int k = 0; k < DEPTH + 3; k++)
                begin
                    advance(0, 50);
                    add(mk_req(pttt_pkg::REQ_SAVE, $urandom_range(0, 40),
                               8'($urandom_range(0, 255)), $urandom_range(1, 3000),
                               $urandom_range(0, 100), 1'b0));
                end
                add(mk_req(pttt_pkg::REQ_REDO, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
            end
            repeat (50) add_random();
            add(mk_req(pttt_pkg::REQ_CHECK, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0));
            drain();
        end

        $display("Sent %0d requests, checked %0d results (%0d restarts, %0d timeouts)",
                 sent_cnt, rsp_cnt, restarts, fails);
        $display("Covered full-table refusals: %0d, retry intervals incl. 0 and max", fulls);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
